// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by polyphase_resampler_fir_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PRF_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PRF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PRF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/prf_pkg.sv
// ----------------------------------------------------------------------------
// prf_pkg
// Shared constants and op codes of the polyphase resampler.
// ----------------------------------------------------------------------------
package prf_pkg;

    // default geometry
    localparam int TAPS_DEF    = 32;
    localparam int PHASES_DEF  = 32;
    localparam int MAX_OUT_DEF = 8;

    // field widths
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PHASE_FW   = 6;
    localparam int TAP_FW     = 5;
    localparam int STEP_W     = 36;
    localparam int FRAC_W     = 32;
    localparam int INTERP_W   = 15;
    localparam int MULB_W     = 32;
    localparam int PROD_W     = COEF_W + MULB_W;

    // step register reset: one input per output
    localparam logic [STEP_W-1:0] STEP_RESET = 36'h1_0000_0000;

    // op codes
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

// File: rtl/prf_ram.sv
// ----------------------------------------------------------------------------
// prf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1056
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/polyphase_resampler_fir_top.sv
// ----------------------------------------------------------------------------
// polyphase_resampler_fir_top
// Fractional polyphase FIR resampler for signed 16-bit audio.
// ----------------------------------------------------------------------------
// Each request carries an op: push a sample, write one coefficient, or clear
// history and position. A push produces up to MAX_OUT_PER_INPUT outputs,
// computed one after another with one shared 16x32 multiplier and the single
// read port of the coefficient RAM: each tap needs two coefficient reads and
// three multiplies (blend of two phase rows, then the history product).
// in_stall is high while a push is being worked on. The output register holds
// one result; the block waits while it is full and out_stall is high.
// step_q32 may be written only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyphase_resampler_fir_top #(
    parameter int TAPS              = prf_pkg::TAPS_DEF,
    parameter int PHASES            = prf_pkg::PHASES_DEF,
    parameter int MAX_OUT_PER_INPUT = prf_pkg::MAX_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prf_pkg::STEP_W-1:0]          step_q32,
    // input requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [prf_pkg::OP_W-1:0]            op,
    input  logic signed [prf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [$clog2(PHASES+1)-1:0]         coef_phase,
    input  logic [$clog2(TAPS)-1:0]             coef_tap,
    input  logic signed [prf_pkg::COEF_W-1:0]   coef_value,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [prf_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                last
);

    localparam int TW       = $clog2(TAPS);
    localparam int DEPTH    = (PHASES + 1) * TAPS;
    localparam int AW       = $clog2(DEPTH);
    localparam int PH_W     = $clog2(PHASES + 1);
    localparam int SCALED_W = prf_pkg::FRAC_W + PH_W;
    localparam int RAW_W    = $clog2(3 * TAPS + 2);
    localparam int NW       = $clog2(MAX_OUT_PER_INPUT + 1);
    localparam int ACC_W    = prf_pkg::PROD_W - 1 + TW + 1;
    localparam int SUM_W    = prf_pkg::STEP_W + 1;
    localparam int ADV_W    = SUM_W - prf_pkg::FRAC_W;
    localparam int THRESH   = TAPS / 2 + 1;
    localparam int BASE_OFS = 2 * TAPS + 1 - TAPS / 2;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP1 = 4'd1;
    localparam logic [3:0] S_SETUP2 = 4'd2;
    localparam logic [3:0] S_TA     = 4'd3;
    localparam logic [3:0] S_TB     = 4'd4;
    localparam logic [3:0] S_TC     = 4'd5;
    localparam logic [3:0] S_TD     = 4'd6;
    localparam logic [3:0] S_TE     = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_ROUND  = 4'd9;
    localparam logic [3:0] S_ADV    = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic signed [prf_pkg::SAMPLE_W-1:0] hist_reg [TAPS];
    logic signed [prf_pkg::SAMPLE_W-1:0] hist_next [TAPS];
    logic [TW-1:0] wi_reg, wi_next;
    logic [TW-1:0] lead_reg, lead_next;
    logic [prf_pkg::FRAC_W-1:0] pos_reg, pos_next;
    logic [prf_pkg::STEP_W-1:0] step_reg, step_next;
    logic [NW-1:0] ncnt_reg, ncnt_next;
    logic [SCALED_W-1:0] scaled_reg, scaled_next;
    logic [RAW_W-1:0] raw_reg, raw_next;
    logic [AW-1:0] qbase_reg, qbase_next;
    logic [prf_pkg::INTERP_W-1:0] r_reg, r_next;
    logic [prf_pkg::INTERP_W:0] ra_reg, ra_next;
    logic [TW-1:0] hidx_reg, hidx_next;
    logic [TW-1:0] tcnt_reg, tcnt_next;
    logic signed [prf_pkg::MULB_W-1:0] c_reg, c_next;
    logic signed [prf_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [prf_pkg::SAMPLE_W-1:0] y_reg, y_next;
    logic last_reg, last_next;
    logic out_valid_reg, out_valid_next;
    logic signed [prf_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic out_last_reg, out_last_next;

    logic in_accept;
    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic signed [prf_pkg::COEF_W-1:0] ram_rdata;
    logic signed [prf_pkg::COEF_W-1:0] mul_a;
    logic signed [prf_pkg::MULB_W-1:0] mul_b;
    logic signed [prf_pkg::PROD_W-1:0] mul_p;
    logic [PH_W-1:0] q_raw;
    logic [PH_W-1:0] q_sel;
    logic [TW:0] lead_inc;
    logic [SUM_W-1:0] pos_sum;
    logic [ADV_W-1:0] adv;
    logic [TW-1:0] lead_adv;
    logic signed [ACC_W-1:0] rsum;
    logic signed [ACC_W-1:0] y_full;
    logic out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign last       = out_last_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // coefficient store
    assign ram_we = in_accept && (op == prf_pkg::OP_COEF)
                    && (32'(coef_phase) <= PHASES) && (32'(coef_tap) < TAPS);
    assign ram_waddr = AW'(32'(coef_phase) * TAPS + 32'(coef_tap));
    assign ram_raddr = (state_reg == S_TB) ? AW'(qbase_reg + AW'(TAPS) + AW'(tcnt_reg))
                                           : AW'(qbase_reg + AW'(tcnt_reg));

    prf_ram #(
        .WIDTH (prf_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (coef_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = ram_rdata;
        mul_b = $signed({{(prf_pkg::MULB_W-prf_pkg::INTERP_W-1){1'b0}}, ra_reg});
        case (state_reg)
            S_TC:
            begin
                mul_b = $signed({{(prf_pkg::MULB_W-prf_pkg::INTERP_W){1'b0}}, r_reg});
            end
            S_TE:
            begin
                mul_a = hist_reg[hidx_reg];
                mul_b = c_reg;
            end
            default:
            begin
                mul_a = ram_rdata;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // phase pick and helpers
    assign q_raw    = scaled_reg[SCALED_W-1:prf_pkg::FRAC_W];
    assign q_sel    = (32'(q_raw) >= PHASES) ? PH_W'(PHASES - 1) : q_raw;
    assign lead_inc = (32'(lead_reg) < TAPS - 1) ? ({1'b0, lead_reg} + 1'b1)
                                                 : {1'b0, lead_reg};
    assign pos_sum  = SUM_W'(pos_reg) + SUM_W'(step_reg);
    assign adv      = pos_sum[SUM_W-1:prf_pkg::FRAC_W];
    assign lead_adv = (32'(lead_reg) > 32'(adv)) ? TW'(32'(lead_reg) - 32'(adv)) : '0;
    assign rsum     = acc_reg + ACC_W'(1 << 29);
    assign y_full   = rsum >>> 30;

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        hist_next       = hist_reg;
        wi_next         = wi_reg;
        lead_next       = lead_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        ncnt_next       = ncnt_reg;
        scaled_next     = scaled_reg;
        raw_next        = raw_reg;
        qbase_next      = qbase_reg;
        r_next          = r_reg;
        ra_next         = ra_reg;
        hidx_next       = hidx_reg;
        tcnt_next       = tcnt_reg;
        c_next          = c_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        y_next          = y_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            step_next = step_q32;
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && op == prf_pkg::OP_PUSH)
                begin
                    hist_next[wi_reg] = sample_in;
                    wi_next   = (32'(wi_reg) == TAPS - 1) ? '0 : wi_reg + 1'b1;
                    lead_next = lead_inc[TW-1:0];
                    ncnt_next = '0;
                    if (32'(lead_inc) >= THRESH)
                    begin
                        state_next = S_SETUP1;
                    end
                end
                else if (in_accept && op == prf_pkg::OP_CLEAR)
                begin
                    for (int i = 0; i < TAPS; i++)
                    begin
                        hist_next[i] = '0;
                    end
                    wi_next   = '0;
                    lead_next = '0;
                    pos_next  = '0;
                end
            end
            S_SETUP1:
            begin
                scaled_next = SCALED_W'(pos_reg) * SCALED_W'(PHASES);
                raw_next    = RAW_W'(wi_reg) + RAW_W'(BASE_OFS) - RAW_W'(lead_reg);
                state_next  = S_SETUP2;
            end
            S_SETUP2:
            begin
                qbase_next = AW'(32'(q_sel) * TAPS);
                r_next     = scaled_reg[31:17];
                ra_next    = (prf_pkg::INTERP_W+1)'(32768)
                             - (prf_pkg::INTERP_W+1)'(scaled_reg[31:17]);
                if (32'(raw_reg) >= 2 * TAPS)
                begin
                    hidx_next = TW'(raw_reg - RAW_W'(2 * TAPS));
                end
                else if (32'(raw_reg) >= TAPS)
                begin
                    hidx_next = TW'(raw_reg - RAW_W'(TAPS));
                end
                else
                begin
                    hidx_next = TW'(raw_reg);
                end
                tcnt_next  = '0;
                acc_next   = '0;
                state_next = S_TA;
            end
            S_TA:
            begin
                // fold previous tap product
                if (tcnt_reg != '0)
                begin
                    acc_next = acc_reg + ACC_W'(prod_reg);
                end
                state_next = S_TB;
            end
            S_TB:
            begin
                prod_next  = mul_p;
                state_next = S_TC;
            end
            S_TC:
            begin
                c_next     = prod_reg[prf_pkg::MULB_W-1:0];
                prod_next  = mul_p;
                state_next = S_TD;
            end
            S_TD:
            begin
                c_next     = c_reg + prod_reg[prf_pkg::MULB_W-1:0];
                state_next = S_TE;
            end
            S_TE:
            begin
                prod_next = mul_p;
                hidx_next = (32'(hidx_reg) == TAPS - 1) ? '0 : hidx_reg + 1'b1;
                if (32'(tcnt_reg) == TAPS - 1)
                begin
                    tcnt_next  = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    tcnt_next  = tcnt_reg + 1'b1;
                    state_next = S_TA;
                end
            end
            S_FIN:
            begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                // round at bit 30, saturate
                if (y_full > ACC_W'(32767))
                begin
                    y_next = 16'sh7fff;
                end
                else if (y_full < -ACC_W'(32768))
                begin
                    y_next = -16'sh8000;
                end
                else
                begin
                    y_next = y_full[prf_pkg::SAMPLE_W-1:0];
                end
                state_next = S_ADV;
            end
            S_ADV:
            begin
                pos_next   = pos_sum[prf_pkg::FRAC_W-1:0];
                lead_next  = lead_adv;
                ncnt_next  = ncnt_reg + 1'b1;
                last_next  = !((32'(ncnt_reg) + 1 < MAX_OUT_PER_INPUT)
                               && (32'(lead_adv) >= THRESH));
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = y_reg;
                    out_last_next   = last_reg;
                    state_next      = last_reg ? S_IDLE : S_SETUP1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= '0;
            end
            wi_reg        <= '0;
            lead_reg      <= '0;
            pos_reg       <= '0;
            step_reg      <= prf_pkg::STEP_RESET;
            ncnt_reg      <= '0;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            wi_reg        <= wi_next;
            lead_reg      <= lead_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            ncnt_reg      <= ncnt_next;
            tcnt_reg      <= tcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        scaled_reg     <= scaled_next;
        raw_reg        <= raw_next;
        qbase_reg      <= qbase_next;
        r_reg          <= r_next;
        ra_reg         <= ra_next;
        hidx_reg       <= hidx_next;
        c_reg          <= c_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        y_reg          <= y_next;
        last_reg       <= last_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    // checks
    `PRF_ASSERT(a_lead_range, 32'(lead_reg) <= TAPS - 1, "input lead out of range")
    `PRF_ASSERT(a_ncnt_range, 32'(ncnt_reg) <= MAX_OUT_PER_INPUT, "too many outputs")
    `PRF_ASSERT_IMP(a_fin_wrap, state_reg == S_FIN, tcnt_reg == '0, "tap count not wrapped")
    `PRF_ASSERT_NXT(a_emit_load, state_reg == S_EMIT && out_free, out_valid_reg, "result not loaded")

endmodule

// File: dv/polyphase_resampler_fir_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyphase_resampler_fir_checker
// Watches the config, request and result channels of the resampler, keeps
// its own copy of filter history, coefficient table and output position,
// predicts the outputs of every accepted push and compares them in order.
// ----------------------------------------------------------------------------
module polyphase_resampler_fir_checker #(
    parameter int TAPS    = prf_pkg::TAPS_DEF,
    parameter int PHASES  = prf_pkg::PHASES_DEF,
    parameter int MAX_OUT = prf_pkg::MAX_OUT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [prf_pkg::STEP_W-1:0]          step_q32,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [prf_pkg::OP_W-1:0]            op,
    input  logic signed [prf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic [prf_pkg::PHASE_FW-1:0]        coef_phase,
    input  logic [prf_pkg::TAP_FW-1:0]          coef_tap,
    input  logic signed [prf_pkg::COEF_W-1:0]   coef_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [prf_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  push_count,
    output int                                  result_count
);
    import prf_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } audio_out_t;

    audio_out_t                 expected_out_q[$];
    logic signed [SAMPLE_W-1:0] history [TAPS];
    logic signed [COEF_W-1:0]   coef_tbl [(PHASES+1)*TAPS];
    int unsigned                wr_ptr;
    int unsigned                lead;
    logic [FRAC_W-1:0]          frac;
    logic [STEP_W-1:0]          step;

    // one filtered output at the current position
    function automatic logic signed [SAMPLE_W-1:0] filter_output();
        logic [63:0] scaled;
        int unsigned q;
        int unsigned base;
        longint      r;
        longint      ra;
        longint      c;
        longint      acc;
        longint      y;
        scaled = {32'd0, frac} * 64'(PHASES);
        q      = scaled[63:32];
        r      = longint'((scaled >> 17) & 64'h7fff);
        ra     = 32768 - r;
        if (q >= PHASES)
            q = PHASES - 1;
        base = (wr_ptr + 2 * TAPS - lead - TAPS / 2 + 1) % TAPS;
        acc  = 0;
        for (int t = 0; t < TAPS; t++)
        begin
            c = longint'(coef_tbl[q*TAPS+t]) * ra + longint'(coef_tbl[(q+1)*TAPS+t]) * r;
            acc += longint'(history[(base+t)%TAPS]) * c;
        end
        // round at bit 30, floor shift
        y = (acc + (longint'(1) << 29)) >>> 30;
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return y[SAMPLE_W-1:0];
    endfunction

    // push a sample and queue the outputs it releases
    task automatic predict_push(input logic signed [SAMPLE_W-1:0] s);
        int          n;
        logic [63:0] sum;
        int unsigned adv;
        audio_out_t  res;
        n = 0;
        history[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % TAPS;
        if (lead < TAPS - 1)
            lead++;
        while (lead >= TAPS / 2 + 1 && n < MAX_OUT)
        begin
            res.sample = filter_output();
            res.last   = 1'b0;
            expected_out_q.push_back(res);
            n++;
            sum  = {32'd0, frac} + {28'd0, step};
            adv  = sum[63:32];
            frac = sum[31:0];
            lead = (lead > adv) ? lead - adv : 0;
        end
        if (n > 0)
            expected_out_q[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        audio_out_t exp_res;
        if (!rst_n)
        begin
            expected_out_q.delete();
            foreach (history[i]) history[i] = '0;
            foreach (coef_tbl[i]) coef_tbl[i] = '0;
            wr_ptr       = 0;
            lead         = 0;
            frac         = '0;
            step         = STEP_RESET;
            fail_count   = 0;
            push_count   = 0;
            result_count = 0;
            pending      = 0;
        end
        else
        begin
            // result side first: it cannot belong to a request taken this edge
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_out_q.size() == 0)
                begin
                    $error("result with no request waiting: sample_out %0d", sample_out);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_out_q.pop_front();
                    if (sample_out !== exp_res.sample)
                    begin
                        $error("sample_out: expected %0d, got %0d", exp_res.sample, sample_out);
                        fail_count++;
                    end
                    if (last !== exp_res.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_res.last, last);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                step = step_q32;
            if (in_valid && !in_stall)
            begin
                case (op)
                    OP_PUSH:
                    begin
                        push_count++;
                        predict_push(sample_in);
                    end
                    OP_COEF:
                        if (coef_phase <= PHASES && coef_tap < TAPS)
                            coef_tbl[coef_phase*TAPS+coef_tap] = coef_value;
                    OP_CLEAR:
                    begin
                        foreach (history[i]) history[i] = '0;
                        wr_ptr = 0;
                        lead   = 0;
                        frac   = '0;
                    end
                    default: ;
                endcase
            end
            pending = expected_out_q.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Resampler test: loads the full coefficient table, runs directed edge cases,
// then random request streams under several step settings with random
// idling on both channels. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import prf_pkg::*;

    localparam int TAPS   = TAPS_DEF;
    localparam int PHASES = PHASES_DEF;
    localparam int LAT    = 5 * TAPS + 16;
    localparam int LIMIT  = 4_000_000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic                   cfg_ready;
    logic [STEP_W-1:0]      step_q32   = STEP_RESET;
    logic                   in_valid   = 1'b0;
    logic                   in_stall;
    logic [OP_W-1:0]        op         = OP_PUSH;
    logic signed [15:0]     sample_in  = '0;
    logic [PHASE_FW-1:0]    coef_phase = '0;
    logic [TAP_FW-1:0]      coef_tap   = '0;
    logic signed [15:0]     coef_value = '0;
    logic                   out_valid;
    logic                   out_stall  = 1'b0;
    logic signed [15:0]     sample_out;
    logic                   last;
    int                     fail_count;
    int                     pending;
    int                     push_count;
    int                     result_count;
    int                     stall_pct  = 0;
    int                     stall_hold = 0;
    bit                     quiet      = 1'b1;
    int                     cycles     = 0;
    int                     settings   = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    polyphase_resampler_fir_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .step_q32(step_q32),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .sample_in(sample_in),
        .coef_phase(coef_phase), .coef_tap(coef_tap), .coef_value(coef_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_out(sample_out), .last(last)
    );

    polyphase_resampler_fir_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .step_q32(step_q32),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .sample_in(sample_in),
        .coef_phase(coef_phase), .coef_tap(coef_tap), .coef_value(coef_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .sample_out(sample_out), .last(last),
        .fail_count(fail_count), .pending(pending),
        .push_count(push_count), .result_count(result_count)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("polyphase_resampler_fir_top verification failed");
            $finish;
        end
    end

    // result back-pressure: short random stalls, now and then a long one
    always @(negedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_hold > 0)
        begin
            stall_hold--;
            out_stall <= 1'b1;
        end
        else if (r < stall_pct)
        begin
            out_stall  <= 1'b1;
            stall_hold = (r < 3) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(15, 80);
    endfunction

    // one request, held until taken, then an optional gap
    task automatic send_req(input logic [OP_W-1:0] o, input logic signed [15:0] s,
                            input logic [PHASE_FW-1:0] ph, input logic [TAP_FW-1:0] tp,
                            input logic signed [15:0] cv);
        int gap;
        gap = sender_gap();
        @(negedge clk);
        in_valid   <= 1'b1;
        op         <= o;
        sample_in  <= s;
        coef_phase <= ph;
        coef_tap   <= tp;
        coef_value <= cv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (LAT) @(negedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        step_q32  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    function automatic logic signed [15:0] rand_coef();
        logic signed [15:0] v;
        v = 16'($urandom);
        return ($urandom_range(0, 3) == 0) ? v : (v >>> 3);
    endfunction

    // random request mix, mostly pushes
    task automatic random_reqs(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (i == n / 2)
                wait_drained();
            if (r < 82)
                send_req(OP_PUSH, 16'($urandom), 6'($urandom), 5'($urandom), 16'($urandom));
            else if (r < 91)
                send_req(OP_COEF, 16'($urandom), 6'($urandom_range(0, PHASES)),
                         5'($urandom), ($urandom_range(0, 1) ? rand_coef() : 16'($urandom)));
            else if (r < 94)
                send_req(OP_COEF, 16'($urandom), 6'($urandom_range(PHASES + 1, 63)),
                         5'($urandom), 16'($urandom));
            else if (r < 97)
                send_req(OP_CLEAR, 16'($urandom), 6'($urandom), 5'($urandom), 16'($urandom));
            else
                send_req(OP_UNUSED, 16'($urandom), 6'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        logic [STEP_W-1:0] steps [7];
        int                counts [7];
        steps  = '{36'h1_0000_0000, 36'h0_2000_0000, 36'h8_0000_0000, 36'hF_FFFF_FFFF,
                   36'h0, 36'h1_8000_0000, 36'h0};
        counts = '{80, 80, 80, 80, 20, 80, 80};
        steps[6] = {4'($urandom_range(0, 7)), 32'($urandom)} | 36'h0_2000_0000;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_step(STEP_RESET);
        // every table entry must be written before any output reads it
        for (int ph = 0; ph <= PHASES; ph++)
            for (int tp = 0; tp < TAPS; tp++)
                send_req(OP_COEF, '0, 6'(ph), 5'(tp), rand_coef());

        // directed: field extremes, corner rows, ignored writes, unused op, full-scale pushes, clear
        send_req(OP_COEF, '0, 6'(PHASES), 5'(TAPS - 1), -16'sd32768);
        send_req(OP_COEF, '0, 6'd0, 5'd0, 16'sd32767);
        send_req(OP_COEF, '0, 6'd63, 5'd31, 16'sd1234);
        send_req(OP_COEF, '0, 6'(PHASES + 1), 5'd0, -16'sd1);
        send_req(OP_UNUSED, 16'sd32767, 6'd63, 5'd31, -16'sd1);
        for (int i = 0; i < 18; i++)
            send_req(OP_PUSH, (i % 2) ? -16'sd32768 : 16'sd32767, 6'd63, 5'd31, -16'sd1);
        send_req(OP_CLEAR, '0, '0, '0, '0);

        // random phases over several step settings
        for (int p = 0; p < 7; p++)
        begin
            write_step(steps[p]);
            quiet     = (p == 0);
            stall_pct = (p == 0) ? 0 : 30;
            random_reqs(counts[p]);
        end

        wait_drained();
        $display("Ran %0d pushes, %0d results checked, %0d step settings, coefficient",
                 push_count, result_count, settings);
        $display("rewrites, clears and ignored requests mixed under random idling");
        if (fail_count == 0)
            $display("polyphase_resampler_fir_top verification clean");
        else
            $display("polyphase_resampler_fir_top verification failed");
        $finish;
    end

endmodule
